// ----- rtl/core/fraction_arith_reduce_macros.svh -----
// assertion macros shared by the fraction_arith_reduce rtl
`ifndef FRACTION_ARITH_REDUCE_MACROS_SVH
`define FRACTION_ARITH_REDUCE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FAR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("far assertion failed");

// next-cycle implication, disabled while reset is low
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("far assertion failed");

`endif

// ----- rtl/core/far_pkg.sv -----
// types, constants and helpers for the fraction arithmetic and reduction block
package far_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 32;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int EXT_W         = 65;
    localparam int MAG_W         = NUM_W;
    localparam int CNT_W         = $clog2(MAG_W + 1);
    localparam int SHF_W         = $clog2(MAG_W);

    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_PASS = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]                      cmd;
        logic signed [OPERAND_WIDTH-1:0] num_a;
        logic signed [OPERAND_WIDTH-1:0] den_a;
        logic signed [OPERAND_WIDTH-1:0] num_b;
        logic signed [OPERAND_WIDTH-1:0] den_b;
        logic                            reduce;
    } t_req;

    typedef struct packed {
        logic signed [NUM_W-1:0] out_num;
        logic signed [DEN_W-1:0] out_den;
        logic                    zero_den_error;
    } t_rsp;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // sign-extend a product to the numerator width, two's complement
    function automatic logic signed [NUM_W-1:0] f_ext_num(input logic signed [PROD_W-1:0] p);
        logic signed [EXT_W-1:0] t;
        t = EXT_W'(p);
        return t[NUM_W-1:0];
    endfunction

    // fit a product to the denominator width (same width, so it passes unchanged), two's complement
    function automatic logic signed [DEN_W-1:0] f_ext_den(input logic signed [PROD_W-1:0] p);
        logic signed [EXT_W-1:0] t;
        t = EXT_W'(p);
        return t[DEN_W-1:0];
    endfunction

endpackage

// ----- rtl/core/far_if.sv -----
// request and response channel interfaces
interface far_req_if;
    import far_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface far_rsp_if;
    import far_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/fraction_arith_reduce.sv -----
// Fraction multiply/add/pass with optional reduction to lowest terms. One request is
// worked at a time and i_req.ready is high only while the sequencer is idle; a finished
// result waits in the output register, so the next request can be taken before it is
// read. Steps per request: accept, the products through the shared multiplier for
// multiply or add (none for pass), a check, then with reduction a binary gcd (one
// shift/subtract step per cycle) followed by two restoring divisions (numerator, then
// denominator), and a hand-off that waits while the output register holds an unread
// result. A zero denominator under reduction returns the unreduced values with
// zero_den_error set; a zero numerator under reduction returns 0/1.
`include "fraction_arith_reduce_macros.svh"

module fraction_arith_reduce (
    input  logic      i_clk,
    input  logic      i_rst_n,
    far_req_if.sink   i_req,
    far_rsp_if.source o_rsp
);
    import far_pkg::*;

    t_state                          r_state;
    t_state                          n_state;
    logic [1:0]                      r_cmd;
    logic                            r_reduce;
    logic signed [OPERAND_WIDTH-1:0] r_na;
    logic signed [OPERAND_WIDTH-1:0] r_da;
    logic signed [OPERAND_WIDTH-1:0] r_nb;
    logic signed [OPERAND_WIDTH-1:0] r_db;
    logic [1:0]                      r_step;
    logic signed [NUM_W-1:0]         r_num;
    logic signed [DEN_W-1:0]         r_den;
    logic                            r_err;
    logic [MAG_W-1:0]                r_gcd;
    logic                            r_out_valid;
    t_rsp                            r_out;

    logic signed [OPERAND_WIDTH-1:0] w_mul_a;
    logic signed [OPERAND_WIDTH-1:0] w_mul_b;
    logic signed [PROD_W-1:0]        w_prod;
    logic                            w_is_arith;
    logic                            w_need_gcd;
    logic                            w_gcd_start;
    logic [MAG_W-1:0]                w_mag_num;
    logic [DEN_W-1:0]                w_mag_den;
    logic [MAG_W-1:0]                w_gcd;
    t_unit_sts                       w_gcd_sts;
    logic                            w_div_start;
    logic [MAG_W-1:0]                w_div_dividend;
    logic [MAG_W-1:0]                w_div_divisor;
    logic [MAG_W-1:0]                w_quo;
    t_unit_sts                       w_div_sts;
    logic                            w_load_out;
    logic                            w_ready;

    assign w_is_arith = (i_req.data.cmd == CMD_MUL) || (i_req.data.cmd == CMD_ADD);
    assign w_need_gcd = r_reduce && (r_den != '0) && (r_num != '0);
    assign w_mag_num  = r_num[NUM_W-1] ? (~MAG_W'(r_num) + MAG_W'(1)) : MAG_W'(r_num);
    assign w_mag_den  = r_den[DEN_W-1] ? (~DEN_W'(r_den) + DEN_W'(1)) : DEN_W'(r_den);

    // products in order: num_a*(den_b or num_b), num_b*den_a, den_a*den_b
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = r_na;
                w_mul_b = (r_cmd == CMD_ADD) ? r_db : r_nb;
            end
            2'd1: begin
                w_mul_a = r_nb;
                w_mul_b = r_da;
            end
            default: begin
                w_mul_a = r_da;
                w_mul_b = r_db;
            end
        endcase
    end

    far_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    far_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (w_mag_num),
        .i_b     (MAG_W'(w_mag_den)),
        .o_gcd   (w_gcd),
        .o_sts   (w_gcd_sts)
    );

    far_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_quo      (w_quo),
        .o_sts      (w_div_sts)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = w_is_arith ? ST_MUL : ST_CHECK;
                end
            end
            ST_MUL: begin
                if (r_step == 2'd3) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_need_gcd ? ST_GCD : ST_FINISH;
            end
            ST_GCD: begin
                if (w_gcd_sts.done) begin
                    n_state = ST_DIV_NUM;
                end
            end
            ST_DIV_NUM: begin
                if (w_div_sts.done) begin
                    n_state = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (w_div_sts.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ready        = 1'b0;
        w_gcd_start    = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = MAG_W'(w_mag_den);
        w_div_divisor  = r_gcd;
        w_load_out     = 1'b0;
        case (r_state)
            ST_IDLE: w_ready = 1'b1;
            ST_CHECK: w_gcd_start = w_need_gcd;
            ST_GCD: begin
                w_div_start    = w_gcd_sts.done;
                w_div_dividend = w_mag_num;
                w_div_divisor  = w_gcd;
            end
            ST_DIV_NUM: w_div_start = w_div_sts.done;
            ST_FINISH: w_load_out = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    r_cmd    <= i_req.data.cmd;
                    r_reduce <= i_req.data.reduce;
                    r_na     <= i_req.data.num_a;
                    r_da     <= i_req.data.den_a;
                    r_nb     <= i_req.data.num_b;
                    r_db     <= i_req.data.den_b;
                    r_step   <= 2'd0;
                    r_err    <= 1'b0;
                    r_num    <= f_ext_num(PROD_W'(i_req.data.num_a));
                    r_den    <= f_ext_den(PROD_W'(i_req.data.den_a));
                end
            end
            ST_MUL: begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd1: r_num <= f_ext_num(w_prod);
                    2'd2: begin
                        if (r_cmd == CMD_ADD) begin
                            r_num <= r_num + f_ext_num(w_prod);
                        end
                    end
                    2'd3: r_den <= f_ext_den(w_prod);
                    default: ;
                endcase
            end
            ST_CHECK: begin
                // zero denominator is checked before zero numerator
                if (r_reduce) begin
                    if (r_den == '0) begin
                        r_err <= 1'b1;
                    end else if (r_num == '0) begin
                        r_den <= DEN_W'(1);
                    end
                end
            end
            ST_GCD: begin
                if (w_gcd_sts.done) begin
                    r_gcd <= w_gcd;
                end
            end
            ST_DIV_NUM: begin
                if (w_div_sts.done) begin
                    r_num <= r_num[NUM_W-1] ? (~NUM_W'(w_quo) + NUM_W'(1)) : NUM_W'(w_quo);
                end
            end
            ST_DIV_DEN: begin
                if (w_div_sts.done) begin
                    r_den <= r_den[DEN_W-1] ? (~DEN_W'(w_quo) + DEN_W'(1)) : DEN_W'(w_quo);
                end
            end
            default: ;
        endcase
    end

    // output register frees the sequencer while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.out_num        <= r_num;
            r_out.out_den        <= r_den;
            r_out.zero_den_error <= r_err;
        end
    end

    assign i_req.ready = w_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    `FAR_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != ST_IDLE)
    `FAR_ASSERT_SAME(a_err_means_zero_den, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.zero_den_error, o_rsp.data.out_den == '0)
    `FAR_ASSERT_SAME(a_gcd_nonzero, i_clk, i_rst_n, w_gcd_sts.done, w_gcd != '0)
    `FAR_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, w_div_sts.done, r_state == ST_DIV_NUM || r_state == ST_DIV_DEN)

endmodule

// ----- rtl/core/far_mult.sv -----
// shared signed multiplier with registered product
module far_mult (
    input  logic                                     i_clk,
    input  logic signed [far_pkg::OPERAND_WIDTH-1:0] i_a,
    input  logic signed [far_pkg::OPERAND_WIDTH-1:0] i_b,
    output logic signed [far_pkg::PROD_W-1:0]        o_prod
);
    import far_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/far_gcd.sv -----
// binary gcd engine: one shift or subtract-and-shift per cycle
module far_gcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [far_pkg::MAG_W-1:0]  i_a,
    input  logic [far_pkg::MAG_W-1:0]  i_b,
    output logic [far_pkg::MAG_W-1:0]  o_gcd,
    output far_pkg::t_unit_sts         o_sts
);
    import far_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [MAG_W-1:0] r_a;
    logic [MAG_W-1:0] r_b;
    logic [SHF_W-1:0] r_k;
    logic [MAG_W-1:0] w_a_minus_b;
    logic [MAG_W-1:0] w_b_minus_a;
    logic             w_a_gt_b;

    assign w_a_minus_b = r_a - r_b;
    assign w_b_minus_a = r_b - r_a;
    assign w_a_gt_b    = r_a > r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_a == r_b) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= '0;
        end else if (r_busy && r_a != r_b) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + SHF_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (w_a_gt_b) begin
                // odd minus odd is even, so halve right away
                r_a <= w_a_minus_b >> 1;
            end else begin
                r_b <= w_b_minus_a >> 1;
            end
        end
    end

    assign o_gcd      = r_a << r_k;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ----- rtl/core/far_div.sv -----
// restoring divider for unsigned magnitudes, one quotient bit per cycle
module far_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [far_pkg::MAG_W-1:0]  i_dividend,
    input  logic [far_pkg::MAG_W-1:0]  i_divisor,
    output logic [far_pkg::MAG_W-1:0]  o_quo,
    output far_pkg::t_unit_sts         o_sts
);
    import far_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] r_quo;
    logic [MAG_W-1:0] r_dvs;
    logic [MAG_W:0]   w_trial;

    assign w_trial = {r_rem, r_quo[MAG_W-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[MAG_W]) begin
                r_rem <= w_trial[MAG_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b1};
            end else begin
                // no borrow room: the shifted remainder stays below the divisor
                r_rem <= {r_rem[MAG_W-2:0], r_quo[MAG_W-1]};
                r_quo <= {r_quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo      = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
